/* rtl/page_translation_unit_assert.svh */
// Assertion macros for the page translation unit.
// Each macro expands to a concurrent assertion, or to nothing when assertions are off.
`ifndef PAGE_TRANSLATION_UNIT_ASSERT_SVH
`define PAGE_TRANSLATION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define PTU_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ptu: same-cycle check failed");
// next-cycle implication, disabled during reset
`define PTU_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ptu: next-cycle check failed");
`else
`define PTU_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define PTU_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/ptu_pkg.sv */
// Package for the page translation unit: payload structs, entry layout,
// op and status codes, register indexes and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package ptu_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int VPN_W       = 25;
    localparam int PPN_W       = 16;
    localparam int PA_W        = 12;
    localparam int ST_W        = 3;
    localparam int OP_W        = 2;
    localparam int SIZE_W      = 2;

    localparam int PAGE_BITS_DEF     = 7;
    localparam int PHYS_PAGES_DEF    = 32;
    localparam int TLB_ENTRIES_DEF   = 4;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE     = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;

    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_ADDR  = 3'd1;
    localparam logic [ST_W-1:0] ST_FAULT = 3'd2;
    localparam logic [ST_W-1:0] ST_RO    = 3'd3;
    localparam logic [ST_W-1:0] ST_BUS   = 3'd4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_TLB    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_SIZE = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  TABLE_SIZE_RST = 7'd64;

    typedef struct packed {
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
        logic             valid;
        logic             read_only;
        logic             used;
        logic             dirty;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [31:0]       vaddr;
        logic [SIZE_W-1:0] size_code;
        logic              is_write;
        logic [IDX_W-1:0]  index;
        logic [VPN_W-1:0]  new_vpn;
        logic [PPN_W-1:0]  new_ppn;
        logic              new_valid;
        logic              new_read_only;
        logic              new_use;
        logic              new_dirty;
    } in_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [PA_W-1:0]  phys_addr;
        logic [VPN_W-1:0] fault_vpn;
        logic [VPN_W-1:0] out_vpn;
        logic [PPN_W-1:0] out_ppn;
        logic             out_valid;
        logic             out_read_only;
        logic             out_use;
        logic             out_dirty;
    } out_t;

endpackage

/* rtl/page_translation_unit.sv */
// Page translation unit: linear page table or associative TLB over one entry store.
// Depends on ptu_pkg and page_translation_unit_assert.svh.
//
// Usage:
//   s_valid/s_ready/s_data carry one request beat (translate, write entry, read entry).
//   m_valid/m_ready/m_data carry one result beat for every request, in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write use_tlb (index 0) or table_size
//   (index 1); cfg_ready is always high and writes are meant for an idle block.
// Pipeline: an accepted request passes through the stage register, then the output register.
// Throughput: one request per cycle unless the output stalls. The entry memory is read at
// the accept edge into the stage register; the stage logic completes the check and writes
// back the use/dirty update (or the new entry) as the result moves to the output register.
// A read issued at the same edge as a write to that entry takes the write data.
// TLB mode searches flop copies of the lowest TLB_ENTRIES entries in parallel.
// Reset: entries read as zero at once through per-entry written bits, so there is
// no clearing pass; use_tlb resets to 1 and table_size to 64.
// Stall: a result held in the output register keeps its beat; one more request
// may sit in the stage register, after which s_ready drops until m_ready returns.
`timescale 1ns / 1ps
`include "page_translation_unit_assert.svh"

module page_translation_unit #(
    parameter int PAGE_BITS     = ptu_pkg::PAGE_BITS_DEF,
    parameter int PHYS_PAGES    = ptu_pkg::PHYS_PAGES_DEF,
    parameter int TLB_ENTRIES   = ptu_pkg::TLB_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = ptu_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ptu_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ptu_pkg::out_t                      m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ptu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W   = ptu_pkg::IDX_W;
    localparam int LIN_MAX = (TABLE_ENTRIES < ptu_pkg::STORE_DEPTH) ?
                             TABLE_ENTRIES : ptu_pkg::STORE_DEPTH;
    localparam logic [31:0] OFS_MASK = 32'((64'd1 << PAGE_BITS) - 64'd1);

    // configuration
    logic                          use_tlb_reg;
    logic [ptu_pkg::CFG_DATA_W-1:0] table_size_reg;

    // store
    ptu_pkg::entry_t               mem [ptu_pkg::STORE_DEPTH];
    logic [ptu_pkg::STORE_DEPTH-1:0] written_reg;
    ptu_pkg::entry_t               shadow_reg [TLB_ENTRIES];

    // stage register
    logic                          p_valid_reg;
    ptu_pkg::in_t                  p_in_reg;
    ptu_pkg::entry_t               rd_data_reg;
    logic                          ent_ok_reg;
    logic                          fwd_reg;
    ptu_pkg::entry_t               fwd_data_reg;

    // output register
    logic                          m_valid_reg;
    ptu_pkg::out_t                 m_data_reg;

    logic                          adv;
    logic                          s_accept;
    logic [31:0]                   s_vpn;
    logic [IDX_W-1:0]              rd_addr;
    logic                          rd_hit;

    logic                          wr_req;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    ptu_pkg::entry_t               wr_data;
    ptu_pkg::out_t                 res;

    logic [31:0]                   vpn;
    logic [31:0]                   pa;
    logic [ptu_pkg::CFG_DATA_W-1:0] bound;
    logic                          misalign;
    ptu_pkg::entry_t               lin_ent;
    ptu_pkg::entry_t               hit_ent;
    ptu_pkg::entry_t               sel_ent;
    logic [IDX_W-1:0]              hit_idx;
    logic                          hit;
    logic                          go;
    logic [IDX_W-1:0]              go_addr;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = !p_valid_reg || adv;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign s_vpn   = s_data.vaddr >> PAGE_BITS;
    assign rd_addr = (s_data.op == ptu_pkg::OP_TRANSLATE && !use_tlb_reg) ?
                     s_vpn[IDX_W-1:0] : s_data.index;
    assign rd_hit  = wr_en && (wr_addr == rd_addr);
    assign wr_en   = wr_req && p_valid_reg && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_tlb_reg    <= 1'b1;
            table_size_reg <= ptu_pkg::TABLE_SIZE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ptu_pkg::REG_USE_TLB:    use_tlb_reg    <= cfg_data[0];
                ptu_pkg::REG_TABLE_SIZE: table_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (s_accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                shadow_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (wr_en && wr_addr == IDX_W'(i)) begin
                    shadow_reg[i] <= wr_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
    end

    // bypass a same-edge write into the new beat's read
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_in_reg     <= s_data;
            ent_ok_reg   <= rd_hit || written_reg[rd_addr];
            fwd_reg      <= rd_hit;
            fwd_data_reg <= wr_data;
        end
    end

    always_comb begin
        vpn      = p_in_reg.vaddr >> PAGE_BITS;
        misalign = (p_in_reg.size_code != ptu_pkg::SIZE_BYTE && p_in_reg.vaddr[0]) ||
                   (p_in_reg.size_code != ptu_pkg::SIZE_BYTE &&
                    p_in_reg.size_code != ptu_pkg::SIZE_HALF && p_in_reg.vaddr[1]);
        bound    = (table_size_reg < 7'(LIN_MAX)) ? table_size_reg : 7'(LIN_MAX);
        lin_ent  = ent_ok_reg ? (fwd_reg ? fwd_data_reg : rd_data_reg) : '0;

        // walk downward so the lowest matching entry wins
        hit     = 1'b0;
        hit_idx = '0;
        hit_ent = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (shadow_reg[i].valid && {7'd0, shadow_reg[i].vpn} == vpn) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
                hit_ent = shadow_reg[i];
            end
        end

        res     = '0;
        wr_req  = 1'b0;
        wr_addr = p_in_reg.index;
        wr_data = '0;
        go      = 1'b0;
        go_addr = '0;
        sel_ent = '0;
        pa      = '0;

        case (p_in_reg.op)
            ptu_pkg::OP_TRANSLATE: begin
                if (misalign) begin
                    res.status = ptu_pkg::ST_ADDR;
                end else if (!use_tlb_reg) begin
                    if (vpn >= 32'(bound)) begin
                        res.status = ptu_pkg::ST_ADDR;
                    end else if (!lin_ent.valid) begin
                        res.status    = ptu_pkg::ST_FAULT;
                        res.fault_vpn = vpn[ptu_pkg::VPN_W-1:0];
                    end else begin
                        go      = 1'b1;
                        go_addr = vpn[IDX_W-1:0];
                        sel_ent = lin_ent;
                    end
                end else begin
                    if (!hit) begin
                        res.status    = ptu_pkg::ST_FAULT;
                        res.fault_vpn = vpn[ptu_pkg::VPN_W-1:0];
                    end else if (hit_ent.read_only && p_in_reg.is_write) begin
                        res.status = ptu_pkg::ST_RO;
                    end else begin
                        go      = 1'b1;
                        go_addr = hit_idx;
                        sel_ent = hit_ent;
                    end
                end
                if (go) begin
                    if ({1'b0, sel_ent.ppn} >= 17'(PHYS_PAGES)) begin
                        res.status = ptu_pkg::ST_BUS;
                    end else begin
                        pa            = (32'(sel_ent.ppn) << PAGE_BITS) |
                                        (p_in_reg.vaddr & OFS_MASK);
                        res.status    = ptu_pkg::ST_OK;
                        res.phys_addr = pa[ptu_pkg::PA_W-1:0];
                        // mark referenced, and modified on a store
                        wr_req        = 1'b1;
                        wr_addr       = go_addr;
                        wr_data       = sel_ent;
                        wr_data.used  = 1'b1;
                        wr_data.dirty = sel_ent.dirty | p_in_reg.is_write;
                    end
                end
            end
            ptu_pkg::OP_WRITE: begin
                wr_req            = 1'b1;
                wr_data.vpn       = p_in_reg.new_vpn;
                wr_data.ppn       = p_in_reg.new_ppn;
                wr_data.valid     = p_in_reg.new_valid;
                wr_data.read_only = p_in_reg.new_read_only;
                wr_data.used      = p_in_reg.new_use;
                wr_data.dirty     = p_in_reg.new_dirty;
            end
            ptu_pkg::OP_READ: begin
                res.out_vpn       = lin_ent.vpn;
                res.out_ppn       = lin_ent.ppn;
                res.out_valid     = lin_ent.valid;
                res.out_read_only = lin_ent.read_only;
                res.out_use       = lin_ent.used;
                res.out_dirty     = lin_ent.dirty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p_valid_reg) begin
            m_data_reg <= res;
        end
    end

    `PTU_ASSERT_IMPLY(a_ready_drop, aclk, aresetn, !s_ready, p_valid_reg && m_valid_reg && !m_ready)
    `PTU_ASSERT_IMPLY(a_wr_on_retire, aclk, aresetn, wr_en, p_valid_reg && adv)
    `PTU_ASSERT_IMPLY(a_pa_zero_on_err, aclk, aresetn, m_valid_reg && m_data_reg.status != ptu_pkg::ST_OK, m_data_reg.phys_addr == '0)
    `PTU_ASSERT_IMPLY(a_fvpn_fault_only, aclk, aresetn, m_valid_reg && m_data_reg.fault_vpn != '0, m_data_reg.status == ptu_pkg::ST_FAULT)
    `PTU_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid_reg && !m_ready, $stable(m_data_reg))

endmodule
